@@ hdl/tre_pkg.sv @@
// tre_pkg: shared constants, codes and control structs of the triangle edge rasterizer.
// Used by tre_ctrl, tre_dp and triangle_edge_rasterizer_top; depends on nothing.
`default_nettype none
package tre_pkg;

  localparam int FB_COLS   = 64;
  localparam int FB_ROWS   = 64;
  localparam int FRAC_BITS = 4;

  localparam int CW      = 15;
  localparam int DW      = CW + 1;
  localparam int EW      = 2 * DW;
  localparam int DIM_W   = 7;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = 13;
  localparam int ADDR_W  = $clog2(FB_COLS * FB_ROWS);
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int RIDX_W  = PADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [RIDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [RIDX_W-1:0] REG_DRAW_COLOR    = 2'd2;

  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 24'hFFFFFF;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic load;
    logic box;
    logic mul;
    logic edge_init;
    logic scan;
    logic clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic row_ok;
    logic x_ok;
    logic next_row_ok;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/tre_ram.sv @@
// tre_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/tre_ctrl.sv @@
// tre_ctrl: sequencer of the rasterizer (clear pass, draw setup, scan, read, result).
// Depends on tre_pkg; drives tre_dp through cmd_t and watches sts_t.
`default_nettype none
module tre_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_func,
  output logic               in_stall,
  input  wire tre_pkg::sts_t sts_i,
  output tre_pkg::cmd_t      cmd_o
);
  import tre_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_BOX   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_EDGE  = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_RD    = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = (in_func == FUNC_READ) ? ST_RD : ST_BOX;
        end
      end
      ST_BOX: begin
        cmd_o.box = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        cmd_o.edge_init = 1'b1;
        state_nxt       = sts_i.row_ok ? ST_SCAN : ST_FIN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.x_ok && !sts_i.next_row_ok) begin
          state_nxt = ST_FIN;
        end
      end
      ST_RD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tre_dp.sv @@
// tre_dp: rasterizer datapath: item registers, bounding box, edge setup multipliers,
// incremental edge scan, frame store (tre_ram) and result register. Depends on tre_pkg.
`default_nettype none
module tre_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tre_pkg::cmd_t                 cmd_i,
  output tre_pkg::sts_t                      sts_o,
  input  wire logic                          in_func,
  input  wire tre_pkg::coord_t               in_v0_x,
  input  wire tre_pkg::coord_t               in_v0_y,
  input  wire tre_pkg::coord_t               in_v1_x,
  input  wire tre_pkg::coord_t               in_v1_y,
  input  wire tre_pkg::coord_t               in_v2_x,
  input  wire tre_pkg::coord_t               in_v2_y,
  input  wire logic [tre_pkg::COL_W-1:0]     in_read_col,
  input  wire logic [tre_pkg::ROW_W-1:0]     in_read_row,
  input  wire logic [tre_pkg::DIM_W-1:0]     active_width,
  input  wire logic [tre_pkg::DIM_W-1:0]     active_height,
  input  wire logic [tre_pkg::COLOR_W-1:0]   draw_color,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tre_pkg::COLOR_W-1:0]   out_pixel_rgb,
  output logic      [tre_pkg::CNT_W-1:0]     out_pixels_written
);
  import tre_pkg::*;

  localparam int NXT [3] = '{1, 2, 0};

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // truncate toward zero, clamp negatives to zero, saturate at the store edge
  function automatic logic [DIM_W-1:0] start_of(coord_t m, int lim);
    logic [CW-1:0] t;
    t = m[CW-1] ? '0 : CW'($unsigned(m) >> FRAC_BITS);
    return (t > CW'(lim)) ? DIM_W'(lim) : DIM_W'(t);
  endfunction

  coord_t                   vx_r [3], vx_nxt [3];
  coord_t                   vy_r [3], vy_nxt [3];
  logic                     func_r, func_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [DIM_W-1:0]         xs_r, xs_nxt;
  logic [DIM_W-1:0]         x_r, x_nxt;
  logic [DIM_W-1:0]         y_r, y_nxt;
  coord_t                   maxx_r, maxx_nxt;
  coord_t                   maxy_r, maxy_nxt;
  logic signed [EW-1:0]     prod_a_r [3], prod_a_nxt [3];
  logic signed [EW-1:0]     prod_b_r [3], prod_b_nxt [3];
  logic signed [EW-1:0]     e_r [3], e_nxt [3];
  logic signed [EW-1:0]     erow_r [3], erow_nxt [3];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]       rgb_r, rgb_nxt;
  logic [CNT_W-1:0]         pw_r, pw_nxt;

  logic signed [DW-1:0]     dx [3];
  logic signed [DW-1:0]     dy [3];
  logic signed [DW-1:0]     pa [3];
  logic signed [DW-1:0]     pb [3];
  logic signed [EW-1:0]     stepx [3];
  logic signed [EW-1:0]     stepy [3];
  logic [DIM_W-1:0]         aw, ah, y_inc;
  logic signed [DW-1:0]     px_x, py_y, py_inc;
  logic                     x_ok, row_ok, next_row_ok, covered, rd_in_win;
  logic [ADDR_W-1:0]        pix_addr, rd_addr, ram_waddr;
  logic                     ram_we;
  logic [COLOR_W-1:0]       ram_wdata, ram_rdata;

  assign aw     = (active_width > DIM_W'(FB_COLS)) ? DIM_W'(FB_COLS) : active_width;
  assign ah     = (active_height > DIM_W'(FB_ROWS)) ? DIM_W'(FB_ROWS) : active_height;
  assign y_inc  = y_r + DIM_W'(1);
  assign px_x   = $signed(DW'(x_r) << FRAC_BITS);
  assign py_y   = $signed(DW'(y_r) << FRAC_BITS);
  assign py_inc = $signed(DW'(y_inc) << FRAC_BITS);

  assign x_ok        = (x_r < aw) && (px_x < DW'(maxx_r));
  assign row_ok      = (y_r < ah) && (py_y < DW'(maxy_r));
  assign next_row_ok = (y_inc < ah) && (py_inc < DW'(maxy_r));
  assign covered     = !e_r[0][EW-1] && !e_r[1][EW-1] && !e_r[2][EW-1];
  assign rd_in_win   = (DIM_W'(col_r) < aw) && (DIM_W'(row_r) < ah);

  assign pix_addr = ADDR_W'(y_r) * ADDR_W'(FB_COLS) + ADDR_W'(x_r);
  assign rd_addr  = ADDR_W'(row_r) * ADDR_W'(FB_COLS) + ADDR_W'(col_r);

  assign ram_we    = cmd_i.clr || (cmd_i.scan && x_ok && covered);
  assign ram_waddr = cmd_i.clr ? clr_cnt_r : pix_addr;
  assign ram_wdata = cmd_i.clr ? '0 : draw_color;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx[i]    = DW'(vx_r[NXT[i]]) - DW'(vx_r[i]);
      dy[i]    = DW'(vy_r[NXT[i]]) - DW'(vy_r[i]);
      pa[i]    = px_x - DW'(vx_r[i]);
      pb[i]    = py_y - DW'(vy_r[i]);
      stepx[i] = EW'(dy[i]) <<< FRAC_BITS;
      stepy[i] = EW'(dx[i]) <<< FRAC_BITS;
    end
  end

  always_comb begin
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    func_nxt   = func_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    xs_nxt     = xs_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    maxx_nxt   = maxx_r;
    maxy_nxt   = maxy_r;
    prod_a_nxt = prod_a_r;
    prod_b_nxt = prod_b_r;
    e_nxt      = e_r;
    erow_nxt   = erow_r;
    cnt_nxt    = cnt_r;
    if (cmd_i.load) begin
      vx_nxt   = '{in_v0_x, in_v1_x, in_v2_x};
      vy_nxt   = '{in_v0_y, in_v1_y, in_v2_y};
      func_nxt = in_func;
      col_nxt  = in_read_col;
      row_nxt  = in_read_row;
      cnt_nxt  = '0;
    end
    if (cmd_i.box) begin
      xs_nxt   = start_of(min3(vx_r[0], vx_r[1], vx_r[2]), FB_COLS);
      x_nxt    = start_of(min3(vx_r[0], vx_r[1], vx_r[2]), FB_COLS);
      y_nxt    = start_of(min3(vy_r[0], vy_r[1], vy_r[2]), FB_ROWS);
      maxx_nxt = max3(vx_r[0], vx_r[1], vx_r[2]);
      maxy_nxt = max3(vy_r[0], vy_r[1], vy_r[2]);
    end
    if (cmd_i.mul) begin
      for (int i = 0; i < 3; i++) begin
        prod_a_nxt[i] = EW'(pa[i]) * EW'(dy[i]);
        prod_b_nxt[i] = EW'(pb[i]) * EW'(dx[i]);
      end
    end
    if (cmd_i.edge_init) begin
      for (int i = 0; i < 3; i++) begin
        e_nxt[i]    = prod_a_r[i] - prod_b_r[i];
        erow_nxt[i] = prod_a_r[i] - prod_b_r[i];
      end
    end
    if (cmd_i.scan) begin
      if (x_ok) begin
        x_nxt = x_r + DIM_W'(1);
        for (int i = 0; i < 3; i++) begin
          e_nxt[i] = e_r[i] + stepx[i];
        end
        if (covered) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end else begin
        x_nxt = xs_r;
        y_nxt = y_inc;
        for (int i = 0; i < 3; i++) begin
          e_nxt[i]    = erow_r[i] - stepy[i];
          erow_nxt[i] = erow_r[i] - stepy[i];
        end
      end
    end
  end

  always_comb begin
    clr_cnt_nxt   = cmd_i.clr ? clr_cnt_r + ADDR_W'(1) : clr_cnt_r;
    out_valid_nxt = out_valid_r;
    rgb_nxt       = rgb_r;
    pw_nxt        = pw_r;
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
      if (func_r == FUNC_READ) begin
        rgb_nxt = rd_in_win ? ram_rdata : '0;
        pw_nxt  = '0;
      end else begin
        rgb_nxt = '0;
        pw_nxt  = cnt_r;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    func_r   <= func_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    xs_r     <= xs_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    maxx_r   <= maxx_nxt;
    maxy_r   <= maxy_nxt;
    prod_a_r <= prod_a_nxt;
    prod_b_r <= prod_b_nxt;
    e_r      <= e_nxt;
    erow_r   <= erow_nxt;
    cnt_r    <= cnt_nxt;
    rgb_r    <= rgb_nxt;
    pw_r     <= pw_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  tre_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FB_COLS * FB_ROWS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign sts_o.clr_last    = (clr_cnt_r == ADDR_W'(FB_COLS * FB_ROWS - 1));
  assign sts_o.row_ok      = row_ok;
  assign sts_o.x_ok        = x_ok;
  assign sts_o.next_row_ok = next_row_ok;
  assign sts_o.out_free    = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_pixel_rgb      = rgb_r;
  assign out_pixels_written = pw_r;

  a_scan_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.scan && ram_we) |-> ((x_r < aw) && (y_r < ah)))
    else $error("scan write outside active window");

  a_count_cleared_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> (cnt_r == '0))
    else $error("pixel count not cleared for new transaction");

  a_clear_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.clr && sts_o.clr_last) |=> (clr_cnt_r == '0))
    else $error("clear counter did not wrap after last entry");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |=> out_valid_r)
    else $error("result register not valid after load");

endmodule
`default_nettype wire

@@ hdl/triangle_edge_rasterizer_top.sv @@
// Draw: accept, bounding box (ST_BOX), edge products (ST_MUL), edge init (ST_EDGE), scan of the
// clipped box row by row (ST_SCAN), then result (ST_FIN); read: accept, ST_RD, ST_FIN. One
// transaction at a time: the scan loop visits one candidate pixel per cycle and writes a store
// entry only for covered pixels. Reset: configuration returns to 64, 64, white; the frame store
// is then cleared to black in a pass, one entry per cycle, during which no transaction is accepted.
// Depends on tre_pkg, tre_ctrl, tre_dp, tre_ram.
`default_nettype none
module triangle_edge_rasterizer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire tre_pkg::coord_t               in_v0_x,
  input  wire tre_pkg::coord_t               in_v0_y,
  input  wire tre_pkg::coord_t               in_v1_x,
  input  wire tre_pkg::coord_t               in_v1_y,
  input  wire tre_pkg::coord_t               in_v2_x,
  input  wire tre_pkg::coord_t               in_v2_y,
  input  wire logic [tre_pkg::COL_W-1:0]     in_read_col,
  input  wire logic [tre_pkg::ROW_W-1:0]     in_read_row,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tre_pkg::COLOR_W-1:0]   out_pixel_rgb,
  output logic      [tre_pkg::CNT_W-1:0]     out_pixels_written,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tre_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tre_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tre_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import tre_pkg::*;

  logic [DIM_W-1:0]   active_width_r, active_width_nxt;
  logic [DIM_W-1:0]   active_height_r, active_height_nxt;
  logic [COLOR_W-1:0] draw_color_r, draw_color_nxt;
  logic [RIDX_W-1:0]  reg_idx;
  logic               cfg_wr;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    active_width_nxt  = active_width_r;
    active_height_nxt = active_height_r;
    draw_color_nxt    = draw_color_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ACTIVE_WIDTH:  active_width_nxt  = pwdata[DIM_W-1:0];
        REG_ACTIVE_HEIGHT: active_height_nxt = pwdata[DIM_W-1:0];
        REG_DRAW_COLOR:    draw_color_nxt    = pwdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ACTIVE_WIDTH:  prdata = PDATA_W'(active_width_r);
      REG_ACTIVE_HEIGHT: prdata = PDATA_W'(active_height_r);
      REG_DRAW_COLOR:    prdata = PDATA_W'(draw_color_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= DIM_W'(FB_COLS);
      active_height_r <= DIM_W'(FB_ROWS);
      draw_color_r    <= DRAW_COLOR_RST;
    end else begin
      active_width_r  <= active_width_nxt;
      active_height_r <= active_height_nxt;
      draw_color_r    <= draw_color_nxt;
    end
  end

  tre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tre_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_func            (in_func),
    .in_v0_x            (in_v0_x),
    .in_v0_y            (in_v0_y),
    .in_v1_x            (in_v1_x),
    .in_v1_y            (in_v1_y),
    .in_v2_x            (in_v2_x),
    .in_v2_y            (in_v2_y),
    .in_read_col        (in_read_col),
    .in_read_row        (in_read_row),
    .active_width       (active_width_r),
    .active_height      (active_height_r),
    .draw_color         (draw_color_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_rgb      (out_pixel_rgb),
    .out_pixels_written (out_pixels_written)
  );

endmodule
`default_nettype wire
